FILE: rtl/apb_pkg.sv
// Shared types, constants and lane helpers for the alpha pixel blender.
// Used by apb_mul_stage, apb_div_stage and alpha_pixel_blend; no dependencies.
`timescale 1ns / 1ps

package apb_pkg;

  localparam int LANES     = 3;
  localparam int LANE_W    = 8;
  localparam int PIX_W     = 24;
  localparam int PROD_W    = 2 * LANE_W;
  localparam int SUM_W     = PROD_W + 1;

  localparam logic [LANE_W-1:0] FULL_ALPHA = 8'hFF;
  localparam logic [LANE_W-1:0] MASK5      = 8'h1F;
  localparam logic [LANE_W-1:0] MASK6      = 8'h3F;
  localparam logic [LANE_W-1:0] MASK8      = 8'hFF;

  typedef enum logic {
    FMT_RGB565 = 1'b0,
    FMT_RGB888 = 1'b1
  } fmt_t;

  typedef logic [LANE_W-1:0] lane_t;
  typedef lane_t             lanes_t [LANES];
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Control that travels with each pixel down the pipeline.
  typedef struct packed {
    logic valid;
    fmt_t fmt;
    logic we;
  } ctrl_t;

  // Split a packed pixel into three zero-extended color lanes.
  function automatic lanes_t unpack_pixel(logic [PIX_W-1:0] pix, fmt_t fmt);
    lanes_t l;
    if (fmt == FMT_RGB888) begin
      l[0] = pix[7:0];
      l[1] = pix[15:8];
      l[2] = pix[23:16];
    end else begin
      l[0] = {3'b000, pix[4:0]};
      l[1] = {2'b00, pix[10:5]};
      l[2] = {3'b000, pix[15:11]};
    end
    return l;
  endfunction

  // Reassemble three lanes into a packed pixel; unused high bits are zero.
  function automatic logic [PIX_W-1:0] pack_pixel(lanes_t l, fmt_t fmt);
    logic [PIX_W-1:0] p;
    if (fmt == FMT_RGB888) begin
      p = {l[2], l[1], l[0]};
    end else begin
      p = {8'h00, l[2][4:0], l[1][5:0], l[0][4:0]};
    end
    return p;
  endfunction

  // Largest legal value of a lane in the given format.
  function automatic lane_t lane_max(logic [1:0] idx, fmt_t fmt);
    lane_t m;
    if (fmt == FMT_RGB888) begin
      m = MASK8;
    end else if (idx == 2'd1) begin
      m = MASK6;
    end else begin
      m = MASK5;
    end
    return m;
  endfunction

endpackage

FILE: rtl/apb_mul_stage.sv
// Weighting stage: multiplies source lanes by alpha and frame lanes by 255-alpha.
// Depends on apb_pkg.
`timescale 1ns / 1ps

module apb_mul_stage
  import apb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  ctrl_t  ctrl_in,
  input  lane_t  alpha,
  input  lanes_t src_lanes,
  input  lanes_t dst_lanes,
  output ctrl_t  ctrl_out,
  output prod_t  prod_s [LANES],
  output prod_t  prod_d [LANES]
);

  ctrl_t ctrl_r;
  prod_t prod_s_r [LANES];
  prod_t prod_d_r [LANES];
  lane_t inv_alpha;

  assign inv_alpha = FULL_ALPHA - alpha;

  // Only the valid bit is reset; the data fields simply follow the input.
  always_ff @(posedge clk) begin
    ctrl_r.fmt <= ctrl_in.fmt;
    ctrl_r.we  <= ctrl_in.we;
    for (int i = 0; i < LANES; i++) begin
      prod_s_r[i] <= src_lanes[i] * alpha;
      prod_d_r[i] <= dst_lanes[i] * inv_alpha;
    end
    if (!rst_n) begin
      ctrl_r.valid <= 1'b0;
    end else begin
      ctrl_r.valid <= ctrl_in.valid;
    end
  end

  assign ctrl_out = ctrl_r;
  assign prod_s   = prod_s_r;
  assign prod_d   = prod_d_r;

endmodule

FILE: rtl/apb_div_stage.sv
// Sum and divide-by-255 stages with the per-lane clamp.
// Depends on apb_pkg.
`timescale 1ns / 1ps

module apb_div_stage
  import apb_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  ctrl_t  ctrl_in,
  input  prod_t  prod_s [LANES],
  input  prod_t  prod_d [LANES],
  output ctrl_t  ctrl_out,
  output lanes_t quot
);

  ctrl_t  ctrl_sum_r;
  ctrl_t  ctrl_quot_r;
  sum_t   sum_r [LANES];
  lanes_t quot_r;
  lanes_t quot_nxt;

  // Only the valid bits are reset; the data fields simply follow the input.
  always_ff @(posedge clk) begin
    ctrl_sum_r.fmt  <= ctrl_in.fmt;
    ctrl_sum_r.we   <= ctrl_in.we;
    ctrl_quot_r.fmt <= ctrl_sum_r.fmt;
    ctrl_quot_r.we  <= ctrl_sum_r.we;
    for (int i = 0; i < LANES; i++) begin
      sum_r[i] <= {1'b0, prod_s[i]} + {1'b0, prod_d[i]};
    end
    quot_r <= quot_nxt;
    if (!rst_n) begin
      ctrl_sum_r.valid  <= 1'b0;
      ctrl_quot_r.valid <= 1'b0;
    end else begin
      ctrl_sum_r.valid  <= ctrl_in.valid;
      ctrl_quot_r.valid <= ctrl_sum_r.valid;
    end
  end

  // x/255 is (x + (x >> 8) + 1) >> 8 for every x up to 255*255.
  always_comb begin
    sum_t t;
    logic [SUM_W-LANE_W-1:0] q;
    lane_t mx;
    for (int i = 0; i < LANES; i++) begin
      t  = sum_r[i] + (sum_r[i] >> LANE_W) + SUM_W'(1);
      q  = t[SUM_W-1:LANE_W];
      mx = lane_max(2'(i), ctrl_sum_r.fmt);
      if (q > {1'b0, mx}) begin
        quot_nxt[i] = mx;
      end else begin
        quot_nxt[i] = q[LANE_W-1:0];
      end
    end
  end

  assign ctrl_out = ctrl_quot_r;
  assign quot     = quot_r;

endmodule

FILE: rtl/alpha_pixel_blend.sv
// Top level of the alpha pixel blender: input register, pipeline and output register.
// Depends on apb_pkg, apb_mul_stage and apb_div_stage.
`timescale 1ns / 1ps

// The blender takes one pixel transfer in every clock cycle and returns the
// result of each start transfer on out_valid for one cycle. The receiver
// cannot stall the result, so busy is always low and the pipeline never
// holds. The register stages are input capture, the 8x8 weighting
// multipliers, the lane sum, the reciprocal divide by 255 with its clamp,
// and the output register. The pixel format is captured with each pixel
// when it enters, so it should be written only while no pixel is in flight.
// Each color field is blended as
// (src*alpha + dst*(255-alpha))/255; with alpha 255 that equals the source and
// with alpha 0 it equals the frame pixel, so both end cases fall out of the
// common path, and only the write flag depends on alpha being zero.
module alpha_pixel_blend
  import apb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       in_alpha,
  input  logic [PIX_W-1:0] in_source_pixel,
  input  logic [PIX_W-1:0] in_frame_pixel,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output logic             out_valid,
  output logic             out_write_enable,
  output logic [PIX_W-1:0] out_blended_pixel
);

  // Pixel format register.
  fmt_t fmt_r;

  // Input capture stage.
  ctrl_t  in_ctrl_r;
  lane_t  alpha_r;
  lanes_t src_r;
  lanes_t dst_r;

  ctrl_t  mul_ctrl;
  prod_t  prod_s [LANES];
  prod_t  prod_d [LANES];
  ctrl_t  div_ctrl;
  lanes_t quot;

  // Output register.
  logic             out_valid_r;
  logic             out_we_r;
  logic [PIX_W-1:0] out_pix_r;

  // Nothing downstream can push back, so every start is taken.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RGB565;
    end else if (cfg_we) begin
      fmt_r <= fmt_t'(cfg_wdata);
    end
  end

  // The lanes are masked to the format on capture; bits 23:16 are dropped in 565 mode.
  // Only the valid bit is reset.
  always_ff @(posedge clk) begin
    in_ctrl_r.fmt <= fmt_r;
    in_ctrl_r.we  <= (in_alpha != 8'h00);
    alpha_r       <= in_alpha;
    src_r         <= unpack_pixel(in_source_pixel, fmt_r);
    dst_r         <= unpack_pixel(in_frame_pixel, fmt_r);
    if (!rst_n) begin
      in_ctrl_r.valid <= 1'b0;
    end else begin
      in_ctrl_r.valid <= start && !busy;
    end
  end

  apb_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_in   (in_ctrl_r),
    .alpha     (alpha_r),
    .src_lanes (src_r),
    .dst_lanes (dst_r),
    .ctrl_out  (mul_ctrl),
    .prod_s    (prod_s),
    .prod_d    (prod_d)
  );

  apb_div_stage u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl_in  (mul_ctrl),
    .prod_s   (prod_s),
    .prod_d   (prod_d),
    .ctrl_out (div_ctrl),
    .quot     (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div_ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_we_r  <= div_ctrl.we;
    out_pix_r <= pack_pixel(quot, div_ctrl.fmt);
  end

  assign out_valid         = out_valid_r;
  assign out_write_enable  = out_we_r;
  assign out_blended_pixel = out_pix_r;

endmodule
